// ===== design/pru_pkg.sv =====
// ---------------------------------------------------------------------------
// pru_pkg: shared types and constants of the page replacement unit
// Policy codes, register indexes, controller states and the cell command.
// ---------------------------------------------------------------------------
`default_nettype none

package pru_pkg;

    localparam int PAGES_DEF      = 512;
    localparam int FRAMES_DEF     = 16;
    localparam int SCORE_BITS_DEF = 16;

    localparam int FAULT_W        = 16;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 5;
    localparam int POLICY_W       = 2;
    localparam int FRAMES_RST     = 16;

    typedef enum logic [POLICY_W-1:0] {
        POL_FIFO = 2'd0,
        POL_LRU  = 2'd1,
        POL_MFU  = 2'd2
    } t_policy;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POLICY = 2'd0,
        REG_FRAMES = 2'd1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_SCAN,
        S_COMMIT
    } t_state;

    typedef struct packed {
        logic age;       // LRU: bump every used frame
        logic hit_zero;  // LRU: hit frame restarts at zero
        logic hit_inc;   // MFU: hit frame counts one more use
    } t_cell_cmd;

endpackage

`default_nettype wire

// ===== design/pru_page_if.sv =====
// ---------------------------------------------------------------------------
// pru_page_if: access request channel
// One page number per beat.
// ---------------------------------------------------------------------------
`default_nettype none

interface pru_page_if #(
    parameter int PAGE_W = 9
) ();
    logic              valid;
    logic              ready;
    logic [PAGE_W-1:0] page;

    modport source (output valid, output page, input ready);
    modport sink   (input valid, input page, output ready);
endinterface

`default_nettype wire

// ===== design/pru_result_if.sv =====
// ---------------------------------------------------------------------------
// pru_result_if: access result channel
// Hit or fault, frame, evicted page and the running fault count per beat.
// ---------------------------------------------------------------------------
`default_nettype none

interface pru_result_if #(
    parameter int PAGE_W  = 9,
    parameter int FRAME_W = 4
) ();
    logic                        valid;
    logic                        ready;
    logic                        fault;
    logic [FRAME_W-1:0]          frame;
    logic                        evicted;
    logic [PAGE_W-1:0]           evicted_page;
    logic [pru_pkg::FAULT_W-1:0] faults_so_far;

    modport source (output valid, output fault, output frame, output evicted,
                     output evicted_page, output faults_so_far, input ready);
    modport sink   (input valid, input fault, input frame, input evicted,
                    input evicted_page, input faults_so_far, output ready);
endinterface

`default_nettype wire

// ===== design/pru_cfg_if.sv =====
// ---------------------------------------------------------------------------
// pru_cfg_if: configuration write channel
// Register index and write data per beat.
// ---------------------------------------------------------------------------
`default_nettype none

interface pru_cfg_if ();
    logic                           valid;
    logic                           ready;
    logic [pru_pkg::CFG_IDX_W-1:0]  index;
    logic [pru_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== design/pru_cell.sv =====
// ---------------------------------------------------------------------------
// pru_cell: one physical frame
// Holds the resident page, used flag and score; matches the current page and
// passes a running max (score, frame) to its right neighbor each cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module pru_cell #(
    parameter int IDX        = 0,
    parameter int PAGE_W     = 9,
    parameter int FRAME_W    = 4,
    parameter int SCORE_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pru_pkg::t_cell_cmd    i_cmd,
    input  logic                  i_hit,
    input  logic                  i_load,
    input  logic                  i_active,
    input  logic [PAGE_W-1:0]     i_page,
    input  logic [SCORE_BITS-1:0] i_best_score,
    input  logic [FRAME_W-1:0]    i_best_idx,
    output logic                  o_used,
    output logic                  o_match,
    output logic [PAGE_W-1:0]     o_page,
    output logic [SCORE_BITS-1:0] o_best_score,
    output logic [FRAME_W-1:0]    o_best_idx
);

    logic                  r_used;
    logic [PAGE_W-1:0]     r_page;
    logic [SCORE_BITS-1:0] r_score;
    logic [SCORE_BITS-1:0] n_score;
    logic [SCORE_BITS-1:0] w_score_inc;
    logic [SCORE_BITS-1:0] r_best_score;
    logic [FRAME_W-1:0]    r_best_idx;
    logic                  w_take;

    assign w_score_inc = (r_score == '1) ? r_score : r_score + 1'b1;

    always_comb begin
        n_score = r_score;
        if (i_load) begin
            n_score = SCORE_BITS'(1);
        end else if (i_hit && i_cmd.hit_zero) begin
            n_score = '0;
        end else if (i_hit && i_cmd.hit_inc) begin
            n_score = w_score_inc;
        end else if (i_cmd.age && r_used) begin
            n_score = w_score_inc;
        end
    end

    // strict compare: an earlier frame keeps a tie
    assign w_take = i_active && (r_score > i_best_score);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= 1'b0;
            r_score <= '0;
        end else begin
            r_score <= n_score;
            if (i_load) begin
                r_used <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_page <= i_page;
        end
        r_best_score <= w_take ? r_score : i_best_score;
        r_best_idx   <= w_take ? FRAME_W'(IDX) : i_best_idx;
    end

    assign o_used       = r_used;
    assign o_match      = r_used && (r_page == i_page);
    assign o_page       = r_page;
    assign o_best_score = r_best_score;
    assign o_best_idx   = r_best_idx;

endmodule

`default_nettype wire

// ===== design/page_replacement_unit.sv =====
// ---------------------------------------------------------------------------
// page_replacement_unit: demand paging frame allocator
// Resident pages sit in a row of frame cells; a hit is a parallel match, a
// victim is chosen by FIFO head or by a max wave along the cell row.
// ---------------------------------------------------------------------------
//  channel       dir  beat contents
//  i_page_ch     in   page
//  o_result_ch   out  fault, frame, evicted, evicted_page, faults_so_far
//  i_cfg_ch      in   index (0 policy, 1 frames_in_use), data
//
//  Hit, free-frame fill or FIFO replacement: states IDLE, LOOK and COMMIT.
//  LRU/MFU replacement adds the SCAN state, held while the max wave crosses
//  the row of frame cells one cell per cycle.
//  One access in flight; the next is taken once the result is registered.
//  Reset is synchronous, active low; config is always ready.
// ---------------------------------------------------------------------------
`default_nettype none

module page_replacement_unit #(
    parameter int PAGES      = pru_pkg::PAGES_DEF,
    parameter int FRAMES     = pru_pkg::FRAMES_DEF,
    parameter int SCORE_BITS = pru_pkg::SCORE_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    pru_page_if.sink     i_page_ch,
    pru_result_if.source o_result_ch,
    pru_cfg_if.sink      i_cfg_ch
);

    localparam int PAGE_W  = $clog2(PAGES);
    localparam int FRAME_W = $clog2(FRAMES);
    localparam int FCNT_W  = $clog2(FRAMES + 1);
    localparam int NW      = (FCNT_W > pru_pkg::CFG_DATA_W) ? FCNT_W : pru_pkg::CFG_DATA_W;

    pru_pkg::t_state               r_state;
    pru_pkg::t_state               n_state;
    logic [pru_pkg::POLICY_W-1:0]  r_policy;
    logic [pru_pkg::CFG_DATA_W-1:0] r_frames;
    pru_pkg::t_policy              w_pol;
    logic [NW-1:0]                 w_fiu;
    logic [FCNT_W-1:0]             w_n;

    logic [PAGE_W-1:0]             r_page;
    logic [FRAME_W-1:0]            r_head;
    logic [FRAME_W-1:0]            r_scan_cnt;
    logic                          r_fault;
    logic                          r_evict;
    logic                          r_from_scan;
    logic [FRAME_W-1:0]            r_frame;
    logic [pru_pkg::FAULT_W-1:0]   r_faults;

    logic                          r_out_valid;
    logic                          r_out_fault;
    logic [FRAME_W-1:0]            r_out_frame;
    logic                          r_out_evicted;
    logic [PAGE_W-1:0]             r_out_evpage;

    logic                          w_in_acc;
    logic                          w_commit;
    pru_pkg::t_cell_cmd            w_cmd;

    logic [FRAMES-1:0]             w_used;
    logic [FRAMES-1:0]             w_match;
    logic [FRAMES-1:0]             w_active;
    logic [FRAMES-1:0]             w_load;
    logic [PAGE_W-1:0]             w_cell_page [FRAMES];
    logic [SCORE_BITS-1:0]         w_chain_score [FRAMES+1];
    logic [FRAME_W-1:0]            w_chain_idx [FRAMES+1];

    logic                          w_hit;
    logic [FRAME_W-1:0]            w_hit_idx;
    logic                          w_free;
    logic [FRAME_W-1:0]            w_free_idx;
    logic [FRAME_W-1:0]            w_fifo_frame;
    logic [FRAME_W-1:0]            w_victim;
    logic [FCNT_W-1:0]             w_victim_p1;

    // ---------------- configuration ----------------
    assign i_cfg_ch.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= pru_pkg::POL_FIFO;
            r_frames <= pru_pkg::CFG_DATA_W'(pru_pkg::FRAMES_RST);
        end else if (i_cfg_ch.valid) begin
            case (i_cfg_ch.index)
                pru_pkg::REG_POLICY: r_policy <= i_cfg_ch.data[pru_pkg::POLICY_W-1:0];
                pru_pkg::REG_FRAMES: r_frames <= i_cfg_ch.data;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (r_policy)
            pru_pkg::POL_LRU: w_pol = pru_pkg::POL_LRU;
            pru_pkg::POL_MFU: w_pol = pru_pkg::POL_MFU;
            default:          w_pol = pru_pkg::POL_FIFO;
        endcase
    end

    // clamp the frame count to 1..FRAMES
    always_comb begin
        w_fiu = NW'(r_frames);
        if (w_fiu == '0) begin
            w_fiu = NW'(1);
        end else if (w_fiu > NW'(FRAMES)) begin
            w_fiu = NW'(FRAMES);
        end
        w_n = w_fiu[FCNT_W-1:0];
    end

    // ---------------- frame cells ----------------
    assign w_chain_score[0] = '0;
    assign w_chain_idx[0]   = '0;

    for (genvar g = 0; g < FRAMES; g++) begin : g_cell
        assign w_active[g] = (FCNT_W'(g) < w_n);
        assign w_load[g]   = w_commit && r_fault && (w_victim == FRAME_W'(g));

        pru_cell #(
            .IDX        (g),
            .PAGE_W     (PAGE_W),
            .FRAME_W    (FRAME_W),
            .SCORE_BITS (SCORE_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (w_cmd),
            .i_hit        ((r_state == pru_pkg::S_LOOK) && w_match[g]),
            .i_load       (w_load[g]),
            .i_active     (w_active[g]),
            .i_page       (r_page),
            .i_best_score (w_chain_score[g]),
            .i_best_idx   (w_chain_idx[g]),
            .o_used       (w_used[g]),
            .o_match      (w_match[g]),
            .o_page       (w_cell_page[g]),
            .o_best_score (w_chain_score[g+1]),
            .o_best_idx   (w_chain_idx[g+1])
        );
    end

    always_comb begin
        w_hit_idx  = '0;
        w_free_idx = '0;
        for (int i = 0; i < FRAMES; i++) begin
            if (w_match[i]) begin
                w_hit_idx = w_hit_idx | FRAME_W'(i);
            end
        end
        for (int i = FRAMES - 1; i >= 0; i--) begin
            if (!w_used[i] && w_active[i]) begin
                w_free_idx = FRAME_W'(i);
            end
        end
    end

    assign w_hit        = |w_match;
    assign w_free       = |(~w_used & w_active);
    assign w_fifo_frame = (FCNT_W'(r_head) < w_n) ? r_head : '0;
    assign w_victim     = r_from_scan ? w_chain_idx[FRAMES] : r_frame;
    assign w_victim_p1  = FCNT_W'(w_victim) + 1'b1;

    // ---------------- control ----------------
    assign w_commit = (r_state == pru_pkg::S_COMMIT) && (!r_out_valid || o_result_ch.ready);
    assign w_in_acc = i_page_ch.valid && i_page_ch.ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            pru_pkg::S_IDLE: begin
                if (i_page_ch.valid) n_state = pru_pkg::S_LOOK;
            end
            pru_pkg::S_LOOK: begin
                if (!w_hit && !w_free && (w_pol != pru_pkg::POL_FIFO)) begin
                    n_state = pru_pkg::S_SCAN;
                end else begin
                    n_state = pru_pkg::S_COMMIT;
                end
            end
            pru_pkg::S_SCAN: begin
                if (r_scan_cnt == FRAME_W'(FRAMES - 1)) n_state = pru_pkg::S_COMMIT;
            end
            pru_pkg::S_COMMIT: begin
                if (w_commit) n_state = pru_pkg::S_IDLE;
            end
            default: n_state = pru_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        i_page_ch.ready = (r_state == pru_pkg::S_IDLE);
        w_cmd.age       = (r_state == pru_pkg::S_LOOK) && (w_pol == pru_pkg::POL_LRU);
        w_cmd.hit_zero  = (w_pol == pru_pkg::POL_LRU);
        w_cmd.hit_inc   = (w_pol == pru_pkg::POL_MFU);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pru_pkg::S_IDLE;
            r_head      <= '0;
            r_faults    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_commit) begin
                r_out_valid <= 1'b1;
                if (r_fault && (r_faults != '1)) begin
                    r_faults <= r_faults + 1'b1;
                end
                if (r_evict && !r_from_scan) begin
                    r_head <= (w_victim_p1 == w_n) ? '0 : w_victim_p1[FRAME_W-1:0];
                end
            end else if (o_result_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            if ({1'b0, i_page_ch.page} >= (PAGE_W + 1)'(PAGES)) begin
                r_page <= i_page_ch.page - PAGE_W'(PAGES);
            end else begin
                r_page <= i_page_ch.page;
            end
        end
        if (r_state == pru_pkg::S_LOOK) begin
            r_scan_cnt  <= '0;
            r_from_scan <= 1'b0;
            if (w_hit) begin
                r_fault <= 1'b0;
                r_evict <= 1'b0;
                r_frame <= w_hit_idx;
            end else if (w_free) begin
                r_fault <= 1'b1;
                r_evict <= 1'b0;
                r_frame <= w_free_idx;
            end else begin
                r_fault     <= 1'b1;
                r_evict     <= 1'b1;
                r_frame     <= w_fifo_frame;
                r_from_scan <= (w_pol != pru_pkg::POL_FIFO);
            end
        end
        if (r_state == pru_pkg::S_SCAN) begin
            r_scan_cnt <= r_scan_cnt + 1'b1;
        end
        if (w_commit) begin
            r_out_fault   <= r_fault;
            r_out_frame   <= w_victim;
            r_out_evicted <= r_evict;
            r_out_evpage  <= r_evict ? w_cell_page[w_victim] : '0;
        end
    end

    assign o_result_ch.valid         = r_out_valid;
    assign o_result_ch.fault         = r_out_fault;
    assign o_result_ch.frame         = r_out_frame;
    assign o_result_ch.evicted       = r_out_evicted;
    assign o_result_ch.evicted_page  = r_out_evpage;
    assign o_result_ch.faults_so_far = r_faults;

`ifndef SYNTHESIS
    a_single_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_match))
        else $error("page resident in more than one frame");

    a_single_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_load))
        else $error("more than one frame loaded");

    a_evict_is_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_evicted |-> r_out_fault)
        else $error("eviction reported on a hit");

    a_faults_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_faults >= $past(r_faults))
        else $error("fault count went down");
`endif

endmodule

`default_nettype wire
